/* sv/mfl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfl_pkg
// Shared types, constants and defaults for the multitap flanger.
// ----------------------------------------------------------------------------
package mfl_pkg;

  localparam int LINE_DEPTH_DEF       = 512;
  localparam int TAP_COUNT_DEF        = 5;
  localparam int TAP_SPACING_DEF      = 10;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LFO_PERIOD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LFO_SHAPE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd6;

  localparam logic [1:0] SHAPE_SQUARE   = 2'd0;
  localparam logic [1:0] SHAPE_TRIANGLE = 2'd1;
  localparam logic [1:0] SHAPE_RAMP     = 2'd2;
  localparam logic [1:0] SHAPE_SINE     = 2'd3;

  localparam logic [21:0] BASE_DELAY_RST    = 22'd983040;
  localparam logic [19:0] MOD_DEPTH_RST     = 20'd524288;
  localparam logic [19:0] LFO_PERIOD_RST    = 20'd240000;
  localparam logic [20:0] RAMP_STEP_RST     = 21'd35;
  localparam logic [31:0] PHASE_STEP_RST    = 32'd17895;
  localparam logic signed [15:0] FB_GAIN_RST = -16'sd31130;

  localparam logic [17:0] OUT_GAIN  = 18'd11469;
  localparam logic [30:0] POLY_SEED = 31'd172272;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_FBM, ST_FBW, ST_SX, ST_SX2, ST_SPM, ST_SPS, ST_SXT,
    ST_SS, ST_SMD, ST_LFO, ST_RDA, ST_RDB, ST_MULB, ST_ACC, ST_OMUL, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_START, OP_FB_MUL, OP_FB_WR, OP_SX, OP_SX2, OP_SPM,
    OP_SPS, OP_SXT, OP_SS, OP_SMD, OP_LFO, OP_RDA, OP_RDB, OP_MULB, OP_ACC,
    OP_OMUL, OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic tap_last;
    logic poly_last;
    logic sine;
    logic out_busy;
  } status_t;

  // sine polynomial coefficients, highest order first after the seed
  function automatic logic [30:0] poly_coef(input logic [1:0] j);
    logic [30:0] c;
    case (j)
      2'd0:    c = 31'd5026994;
      2'd1:    c = 31'd85569306;
      2'd2:    c = 31'd693598668;
      default: c = 31'd1686629713;
    endcase
    return c;
  endfunction

endpackage

/* sv/multitap_flanger_with_lfo.sv */
`timescale 1ns / 1ps
// Sequence: after a word is accepted, the sequencer runs the feedback writes,
//   the LFO step, the tap reads, the output multiply and the output load.
//   The sine shape adds the polynomial steps before the LFO step.
// Flow: a new word is taken only once the last one is through the output load;
//   a word still waiting on m_tready holds the sequencer and so s_tready.
// Reset: synchronous; then a sweep over all TAP_COUNT*2^clog2(LINE_DEPTH) words
//   (2560 at defaults) zeroes the delay lines before s_tready rises.
// ----------------------------------------------------------------------------
// multitap_flanger_with_lfo
// Multitap flanger with feedback and an LFO-swept fractional delay.
// ----------------------------------------------------------------------------
module multitap_flanger_with_lfo #(
  parameter int LINE_DEPTH       = mfl_pkg::LINE_DEPTH_DEF,
  parameter int TAP_COUNT        = mfl_pkg::TAP_COUNT_DEF,
  parameter int TAP_SPACING      = mfl_pkg::TAP_SPACING_DEF,
  parameter int SINE_TABLE_DEPTH = mfl_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // [15:0] sample_in
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // [15:0] sample_out
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import mfl_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer: one state per datapath step
  mfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: delay-line memory, multiplier, LFO and output register
  mfl_dp #(
    .LINE_DEPTH       (LINE_DEPTH),
    .TAP_COUNT        (TAP_COUNT),
    .TAP_SPACING      (TAP_SPACING),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

/* sv/mfl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfl_ctrl
// Sequencer: clear sweep, feedback writes, sine polynomial, LFO, tap reads, output.
// ----------------------------------------------------------------------------
module mfl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  mfl_pkg::status_t st,
  output mfl_pkg::cmd_t    cmd
);
  import mfl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (st.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op     = OP_START;
          state_next = ST_FBM;
        end
      end
      ST_FBM: begin
        cmd.op     = OP_FB_MUL;
        state_next = ST_FBW;
      end
      ST_FBW: begin
        cmd.op = OP_FB_WR;
        if (!st.tap_last)  state_next = ST_FBM;
        else if (st.sine)  state_next = ST_SX;
        else               state_next = ST_LFO;
      end
      ST_SX: begin
        cmd.op     = OP_SX;
        state_next = ST_SX2;
      end
      ST_SX2: begin
        cmd.op     = OP_SX2;
        state_next = ST_SPM;
      end
      ST_SPM: begin
        cmd.op     = OP_SPM;
        state_next = ST_SPS;
      end
      ST_SPS: begin
        cmd.op     = OP_SPS;
        state_next = st.poly_last ? ST_SXT : ST_SPM;
      end
      ST_SXT: begin
        cmd.op     = OP_SXT;
        state_next = ST_SS;
      end
      ST_SS: begin
        cmd.op     = OP_SS;
        state_next = ST_SMD;
      end
      ST_SMD: begin
        cmd.op     = OP_SMD;
        state_next = ST_LFO;
      end
      ST_LFO: begin
        cmd.op     = OP_LFO;
        state_next = ST_RDA;
      end
      ST_RDA: begin
        cmd.op     = OP_RDA;
        state_next = ST_RDB;
      end
      ST_RDB: begin
        cmd.op     = OP_RDB;
        state_next = ST_MULB;
      end
      ST_MULB: begin
        cmd.op     = OP_MULB;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.op     = OP_ACC;
        state_next = st.tap_last ? ST_OMUL : ST_RDA;
      end
      ST_OMUL: begin
        cmd.op     = OP_OMUL;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!st.out_busy) begin
          cmd.op     = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* sv/mfl_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfl_dp
// Datapath: registers, delay line memory, shared multiplier, LFO, taps.
// ----------------------------------------------------------------------------
module mfl_dp #(
  parameter int LINE_DEPTH       = mfl_pkg::LINE_DEPTH_DEF,
  parameter int TAP_COUNT        = mfl_pkg::TAP_COUNT_DEF,
  parameter int TAP_SPACING      = mfl_pkg::TAP_SPACING_DEF,
  parameter int SINE_TABLE_DEPTH = mfl_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mfl_pkg::cmd_t                 cmd,
  output mfl_pkg::status_t              st,
  input  logic [15:0]                   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import mfl_pkg::*;

  localparam int LAW       = $clog2(LINE_DEPTH);
  localparam int TAW       = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int MAW       = TAW + LAW;
  // each line occupies a power-of-two slot, addressed as {tap, index}
  localparam int MEM_DEPTH = TAP_COUNT * (1 << LAW);
  localparam int STW       = $clog2(SINE_TABLE_DEPTH);

  // config
  logic [21:0]        base_delay;
  logic [19:0]        mod_depth;
  logic [19:0]        lfo_period;
  logic [20:0]        ramp_step;
  logic [31:0]        phase_step;
  logic [1:0]         lfo_shape;
  logic signed [15:0] feedback_gain;

  // state
  logic [LAW-1:0]     write_index;
  logic signed [20:0] tap_values [TAP_COUNT];
  logic [22:0]        current_delay;
  logic               lfo_falling;
  logic [19:0]        lfo_time;
  logic [31:0]        sine_phase;

  // work registers
  logic signed [15:0] x;
  logic signed [24:0] sum;
  logic [TAW-1:0]     tap_idx;
  logic [MAW-1:0]     clr_cnt;
  logic [1:0]         poly_j;
  logic [14:0]        x2;
  logic [30:0]        t;
  logic signed [15:0] sin_q;
  logic signed [49:0] acc;
  logic signed [49:0] prod;
  logic signed [20:0] rdata;

  logic signed [20:0] mem [MEM_DEPTH];

  logic signed [31:0] mul_a;
  logic signed [17:0] mul_b;
  logic               mem_we;
  logic [MAW-1:0]     mem_waddr, mem_raddr;
  logic signed [20:0] mem_wdata;

  logic [15:0]        sp;
  logic [14:0]        xs;
  logic [15:0]        frac;
  logic [12:0]        dint;
  logic [LAW-1:0]     pos;
  logic [LAW-1:0]     prv;
  logic signed [20:0] tap_cur;
  logic signed [49:0] fb_sum, fb_q, sin_s, sin_r, md_q, tot, tap_q, out_q;
  logic signed [25:0] lo_s, hi_s, cur_s, d_s;
  logic               time_clr;

  assign cfg_ready = 1'b1;
  assign tap_cur   = tap_values[tap_idx];
  assign frac      = current_delay[15:0];

  // sine table index folded into the first quadrant
  assign sp = {sine_phase[31 -: STW], {(16-STW){1'b0}}};
  assign xs = sp[14] ? (15'd16384 - {1'b0, sp[13:0]}) : {1'b0, sp[13:0]};

  // read positions, circular over LINE_DEPTH
  always_comb begin
    dint = 13'(current_delay[22:16]) + 13'(tap_idx) * 13'(TAP_SPACING);
    if (dint > 13'(LINE_DEPTH - 2)) dint = 13'(LINE_DEPTH - 2);
    if (write_index >= dint[LAW-1:0]) pos = write_index - dint[LAW-1:0];
    else pos = write_index + LAW'(LINE_DEPTH) - dint[LAW-1:0];
    prv = (pos == '0) ? LAW'(LINE_DEPTH - 1) : pos - 1'b1;
  end

  assign st.clr_last  = (clr_cnt == MAW'(MEM_DEPTH - 1));
  assign st.tap_last  = (tap_idx == TAW'(TAP_COUNT - 1));
  assign st.poly_last = (poly_j == 2'd3);
  assign st.sine      = (lfo_shape == SHAPE_SINE);
  assign st.out_busy  = m_tvalid && !m_tready;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_FB_MUL: begin mul_a = 32'(tap_cur);        mul_b = 18'(feedback_gain); end
      OP_SX:     begin mul_a = 32'(xs);             mul_b = 18'(xs);            end
      OP_SPM:    begin mul_a = {1'b0, t};           mul_b = {3'b0, x2};         end
      OP_SXT:    begin mul_a = {1'b0, t};           mul_b = {3'b0, xs};         end
      OP_SMD:    begin mul_a = {12'b0, mod_depth};  mul_b = 18'(sin_q);         end
      OP_RDB:    begin
        mul_a = 32'(rdata);
        mul_b = {1'b0, 17'(17'h10000 - {1'b0, frac})};
      end
      OP_MULB:   begin mul_a = 32'(rdata);          mul_b = {2'b0, frac};       end
      OP_OMUL:   begin mul_a = 32'(sum);            mul_b = OUT_GAIN;           end
      default: ;
    endcase
  end

  // feedback word, truncated toward zero, saturated to 21 bits
  always_comb begin
    fb_sum = (50'(x) <<< 15) + prod;
    fb_q   = (fb_sum + (fb_sum[49] ? 50'sd32767 : 50'sd0)) >>> 15;
    if (fb_q > 50'sd1048575)       fb_q = 50'sd1048575;
    else if (fb_q < -50'sd1048576) fb_q = -50'sd1048576;
  end

  // sine rounding and magnitude clamp
  always_comb begin
    sin_s = prod >>> 14;
    sin_r = (sin_s + 50'sd16384) >>> 15;
    if (sin_r > 50'sd32767) sin_r = 50'sd32767;
  end

  // LFO next delay
  always_comb begin
    lo_s     = $signed({4'b0, base_delay}) - $signed({6'b0, mod_depth});
    if (lo_s < 0) lo_s = '0;
    hi_s     = $signed({4'b0, base_delay}) + $signed({6'b0, mod_depth});
    cur_s    = $signed({3'b0, current_delay});
    md_q     = (prod + (prod[49] ? 50'sd32767 : 50'sd0)) >>> 15;
    d_s      = cur_s;
    time_clr = 1'b0;
    case (lfo_shape)
      SHAPE_SQUARE: begin
        if (lfo_time >= (lfo_period >> 1)) begin
          d_s      = (cur_s == lo_s) ? hi_s : lo_s;
          time_clr = 1'b1;
        end
      end
      SHAPE_TRIANGLE: begin
        if (lfo_falling) d_s = cur_s - $signed({4'b0, ramp_step, 1'b0});
        else             d_s = cur_s + $signed({4'b0, ramp_step, 1'b0});
        if (d_s >= hi_s || d_s <= lo_s) time_clr = 1'b1;
      end
      SHAPE_RAMP: begin
        d_s = cur_s + $signed({5'b0, ramp_step});
        if (d_s >= hi_s) begin
          d_s      = lo_s;
          time_clr = 1'b1;
        end
      end
      default: d_s = $signed({4'b0, base_delay}) + 26'(md_q);
    endcase
    if (d_s < 0)                 d_s = '0;
    else if (d_s > 26'sd8388607) d_s = 26'sd8388607;
  end

  // tap interpolation and output scaling
  always_comb begin
    tot   = acc + prod;
    tap_q = (tot + (tot[49] ? 50'sd65535 : 50'sd0)) >>> 16;
    out_q = (prod + (prod[49] ? 50'sd32767 : 50'sd0)) >>> 15;
    if (out_q > 50'sd32767)       out_q = 50'sd32767;
    else if (out_q < -50'sd32768) out_q = -50'sd32768;
  end

  // memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = '0;
    mem_raddr = {tap_idx, pos};
    if (cmd.op == OP_CLEAR) begin
      mem_we = 1'b1;
    end else if (cmd.op == OP_FB_WR) begin
      mem_we    = 1'b1;
      mem_waddr = {tap_idx, write_index};
      mem_wdata = 21'(fb_q);
    end
    if (cmd.op == OP_RDB) mem_raddr = {tap_idx, prv};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  // product holds while idle or waiting on the output
  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE) prod <= mul_a * mul_b;
  end

  // payload work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        x   <= $signed(s_tdata);
        sum <= 25'($signed(s_tdata));
      end
      OP_SX2: begin
        x2     <= prod[28:14];
        t      <= POLY_SEED;
        poly_j <= 2'd0;
      end
      OP_SPS: begin
        t      <= poly_coef(poly_j) - prod[44:14];
        poly_j <= poly_j + 2'd1;
      end
      OP_SS:   sin_q <= sp[15] ? -16'(sin_r) : 16'(sin_r);
      OP_MULB: acc   <= prod;
      OP_ACC:  sum   <= sum + 25'(tap_q);
      default: ;
    endcase
  end

  // control and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay    <= BASE_DELAY_RST;
      mod_depth     <= MOD_DEPTH_RST;
      lfo_period    <= LFO_PERIOD_RST;
      ramp_step     <= RAMP_STEP_RST;
      phase_step    <= PHASE_STEP_RST;
      lfo_shape     <= SHAPE_SINE;
      feedback_gain <= FB_GAIN_RST;
      write_index   <= '0;
      for (int i = 0; i < TAP_COUNT; i++) tap_values[i] <= '0;
      current_delay <= {1'b0, BASE_DELAY_RST};
      lfo_falling   <= 1'b0;
      lfo_time      <= '0;
      sine_phase    <= '0;
      tap_idx       <= '0;
      clr_cnt       <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT)          m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (cmd.op)
        OP_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        OP_START: tap_idx <= '0;
        OP_FB_WR: tap_idx <= st.tap_last ? '0 : tap_idx + 1'b1;
        OP_LFO: begin
          current_delay <= 23'(d_s);
          lfo_time      <= time_clr ? 20'd1 : lfo_time + 20'd1;
          if (lfo_shape == SHAPE_TRIANGLE && time_clr) lfo_falling <= !lfo_falling;
          if (lfo_shape == SHAPE_SINE) sine_phase <= sine_phase + phase_step;
          tap_idx <= '0;
        end
        OP_ACC: begin
          tap_values[tap_idx] <= 21'(tap_q);
          if (!st.tap_last) tap_idx <= tap_idx + 1'b1;
        end
        OP_OUT: begin
          m_tdata     <= 16'(out_q);
          write_index <= (write_index == LAW'(LINE_DEPTH - 1)) ? '0
                                                                 : write_index + 1'b1;
        end
        default: ;
      endcase
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_DELAY: begin
            base_delay    <= cfg_data[21:0];
            current_delay <= {1'b0, cfg_data[21:0]};
          end
          REG_MOD_DEPTH: begin
            mod_depth     <= cfg_data[19:0];
            current_delay <= {1'b0, base_delay};
          end
          REG_LFO_PERIOD: begin
            lfo_period    <= cfg_data[19:0];
            current_delay <= {1'b0, base_delay};
          end
          REG_RAMP_STEP:     ramp_step     <= cfg_data[20:0];
          REG_PHASE_STEP:    phase_step    <= cfg_data;
          REG_LFO_SHAPE:     lfo_shape     <= cfg_data[1:0];
          REG_FEEDBACK_GAIN: feedback_gain <= $signed(cfg_data[15:0]);
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_out_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |=> m_tvalid)
    else $error("result not presented after output step");
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    tap_idx <= TAW'(TAP_COUNT - 1))
    else $error("tap index out of range");
  a_sine_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SS) |=> (sin_q != -16'sd32768))
    else $error("sine magnitude overflow");
`endif

endmodule

/* verif/multitap_flanger_with_lfo_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multitap_flanger_with_lfo_test
// Streams audio words through the flanger under random idling and stalls and
// checks every output word against a cycle-free behavioral flanger model
// kept in the bench, across several register settings and all LFO shapes.
// ----------------------------------------------------------------------------
module multitap_flanger_with_lfo_test;
  import mfl_pkg::*;

  localparam int DEPTH   = 512;
  localparam int TAPS    = 5;
  localparam int SPACING = 10;
  localparam longint DELAY_TOP = 8388607;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  multitap_flanger_with_lfo dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------- flanger model state ----------------
  longint line_mem [TAPS][DEPTH];
  longint tap_val [TAPS];
  int unsigned wr_ptr;
  longint cur_delay;
  bit falling;
  int unsigned lfo_count;
  bit [31:0] phase;
  longint r_base, r_depth, r_period, r_ramp;
  bit [31:0] r_phase_step;
  bit [1:0] r_shape;
  longint r_fb;

  logic [15:0] pending_words[$];   // words waiting for the driver
  logic [15:0] expected_out[$];    // predicted output words
  int errors = 0;
  bit sender_quiet = 0;  // last part: no idling
  bit hold_arm = 0;      // request one long receiver stall
  bit hold_off = 0;      // receiver stall in progress

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sine_of(bit [31:0] ph);
    longint unsigned idx, p, q, x, x2, t, s;
    idx = (longint'(ph) * 1024) >> 32;
    p = (idx * 65536) / 1024;
    q = (p >> 14) & 3;
    x = p & 16'h3FFF;
    if (q[0]) x = 16384 - x;
    x2 = (x * x) >> 14;
    t = 172272;
    t = 5026994 - ((x2 * t) >> 14);
    t = 85569306 - ((x2 * t) >> 14);
    t = 693598668 - ((x2 * t) >> 14);
    t = 1686629713 - ((x2 * t) >> 14);
    s = (x * t) >> 14;
    s = (s + 16384) >> 15;
    if (s > 32767) s = 32767;
    return q >= 2 ? -longint'(s) : longint'(s);
  endfunction

  task automatic model_reset();
    foreach (line_mem[k, i]) line_mem[k][i] = 0;
    foreach (tap_val[k]) tap_val[k] = 0;
    wr_ptr = 0; falling = 0; lfo_count = 0; phase = 0;
    r_base = BASE_DELAY_RST; r_depth = MOD_DEPTH_RST; r_period = LFO_PERIOD_RST;
    r_ramp = RAMP_STEP_RST; r_phase_step = PHASE_STEP_RST; r_shape = SHAPE_SINE;
    r_fb = FB_GAIN_RST; cur_delay = r_base;
  endtask

  task automatic model_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    case (idx)
      REG_BASE_DELAY:    begin r_base = v[21:0]; cur_delay = r_base; end
      REG_MOD_DEPTH:     begin r_depth = v[19:0]; cur_delay = r_base; end
      REG_LFO_PERIOD:    begin r_period = v[19:0]; cur_delay = r_base; end
      REG_RAMP_STEP:     r_ramp = v[20:0];
      REG_PHASE_STEP:    r_phase_step = v;
      REG_LFO_SHAPE:     r_shape = v[1:0];
      REG_FEEDBACK_GAIN: r_fb = longint'($signed(v[15:0]));
      default: ;
    endcase
  endtask

  // one audio word in, one predicted word out
  function automatic logic [15:0] flange(logic [15:0] din);
    longint x, acc, lo, hi, d, a, b;
    int unsigned di, f, pos, prv;
    x = longint'($signed(din));
    acc = x;
    for (int k = 0; k < TAPS; k++)
      line_mem[k][wr_ptr] = sat((x * 32768 + tap_val[k] * r_fb) / 32768,
                                -1048576, 1048575);
    lo = r_base - r_depth; hi = r_base + r_depth; d = cur_delay;
    if (lo < 0) lo = 0;
    case (r_shape)
      SHAPE_SQUARE: if (lfo_count >= (r_period >> 1)) begin
        d = (d == lo) ? hi : lo; lfo_count = 0;
      end
      SHAPE_TRIANGLE: begin
        d = falling ? d - 2 * r_ramp : d + 2 * r_ramp;
        if (d >= hi || d <= lo) begin falling = !falling; lfo_count = 0; end
      end
      SHAPE_RAMP: begin
        d += r_ramp;
        if (d >= hi) begin d = lo; lfo_count = 0; end
      end
      default: begin
        d = r_base + (r_depth * sine_of(phase)) / 32768;
        phase += r_phase_step;
      end
    endcase
    cur_delay = sat(d, 0, DELAY_TOP);
    lfo_count = (lfo_count + 1) & 20'hFFFFF;
    for (int k = 0; k < TAPS; k++) begin
      di = int'(cur_delay >> 16) + k * SPACING;
      f = int'(cur_delay & 16'hFFFF);
      if (di > DEPTH - 2) di = DEPTH - 2;
      pos = (wr_ptr + DEPTH - di) % DEPTH;
      prv = (pos + DEPTH - 1) % DEPTH;
      a = line_mem[k][pos]; b = line_mem[k][prv];
      tap_val[k] = (a * longint'(65536 - f) + b * longint'(f)) / 65536;
      acc += tap_val[k];
    end
    acc = sat((acc * 11469) / 32768, -32768, 32767);
    wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
    return acc[15:0];
  endfunction

  // ---------------- driver ----------------
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_out.push_back(flange(s_tdata));
      if (s_tvalid && !s_tready) begin
        // hold current word
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_words.size() > 0 &&
                   (sender_quiet || $urandom_range(0, 9) != 0)) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_words.pop_front();
      end else begin
        s_tvalid <= 1'b0;
        if (!sender_quiet && pending_words.size() > 0)
          send_gap <= $urandom_range(1, 15);
      end
    end
  end

  // ---------------- long receiver stall ----------------
  int hold_cnt = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) hold_off <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_off  <= 1'b1;
      hold_cnt  <= 2000;
      hold_done <= 1'b1;
    end
  end

  // ---------------- monitor / sink ----------------
  int sink_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_out.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output word %h", m_tdata);
        end else begin
          logic [15:0] want;
          want = expected_out.pop_front();
          if (want !== m_tdata) begin
            errors++;
            if (errors <= 10)
              $display("sample_out mismatch: expected %h got %h", want, m_tdata);
          end
        end
      end
      if (hold_off) begin
        m_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 1'b0;
      end else if (!sender_quiet && $urandom_range(0, 11) == 0) begin
        sink_gap <= $urandom_range(1, 15);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------- sequencing ----------------
  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_write(idx, v);
  endtask

  // wait until the block has drained, then a latency's worth of quiet
  task automatic drain();
    while (pending_words.size() > 0 || s_tvalid || expected_out.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic feed_random(int n);
    for (int i = 0; i < n; i++)
      case ($urandom_range(0, 5))
        0: pending_words.push_back($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
        1: pending_words.push_back(16'($urandom_range(0, 511) - 256));
        default: pending_words.push_back(16'($urandom));
      endcase
  endtask

  initial begin
    model_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes and a short impulse at reset settings
    pending_words.push_back(16'h7FFF); pending_words.push_back(16'h8000);
    pending_words.push_back(16'h0000); pending_words.push_back(16'hFFFF);
    pending_words.push_back(16'h0001); pending_words.push_back(16'h5555);
    pending_words.push_back(16'hAAAA);
    for (int i = 0; i < 8; i++) pending_words.push_back(16'h7FFF);
    feed_random(200);
    drain();

    // square, short period (toggle every step), extreme depth, full gain
    reg_write(REG_LFO_SHAPE, 32'(SHAPE_SQUARE));
    reg_write(REG_BASE_DELAY, 32'd327680);
    reg_write(REG_MOD_DEPTH, 32'd983040);     // min saturates at zero
    reg_write(REG_LFO_PERIOD, 32'd1);
    reg_write(REG_FEEDBACK_GAIN, 32'hFFFF8000);
    feed_random(200);
    drain();
    reg_write(REG_LFO_PERIOD, 32'd16);
    reg_write(REG_FEEDBACK_GAIN, 32'd0);
    feed_random(150);
    drain();

    // triangle; long receiver hold-off fills the pipe
    reg_write(REG_LFO_SHAPE, 32'(SHAPE_TRIANGLE));
    reg_write(REG_BASE_DELAY, 32'd1310720);
    reg_write(REG_MOD_DEPTH, 32'd655360);
    reg_write(REG_RAMP_STEP, 32'd40000);
    reg_write(REG_FEEDBACK_GAIN, 32'hFFFFC000);
    feed_random(250);
    hold_arm = 1;
    drain();

    // ramp with a large step, base delay at the top of its range
    reg_write(REG_LFO_SHAPE, 32'(SHAPE_RAMP));
    reg_write(REG_BASE_DELAY, 32'h3FFFFF);
    reg_write(REG_MOD_DEPTH, 32'd0);
    reg_write(REG_RAMP_STEP, 32'd1835008);
    feed_random(150);
    drain();
    reg_write(REG_BASE_DELAY, 32'd0);
    reg_write(REG_MOD_DEPTH, 32'd983040);
    reg_write(REG_RAMP_STEP, 32'd0);
    feed_random(150);
    drain();
    reg_write(REG_RAMP_STEP, 32'd20000);
    reg_write(REG_FEEDBACK_GAIN, 32'h00004000);   // positive gain used as given
    feed_random(200);
    drain();

    // sine with a fast and a maximal phase step; unknown register ignored
    reg_write(REG_LFO_SHAPE, 32'(SHAPE_SINE));
    reg_write(REG_BASE_DELAY, 32'd2000000);
    reg_write(REG_FEEDBACK_GAIN, 32'hFFFF8666);
    reg_write(REG_PHASE_STEP, 32'h0100_0000);
    reg_write(REG_UNUSED, 32'hFFFFFFFF);
    feed_random(200);
    drain();
    reg_write(REG_PHASE_STEP, 32'hFFFFFFFF);
    reg_write(REG_LFO_PERIOD, 32'hFFFFF);
    feed_random(150);
    drain();

    // final stretch without idling
    reg_write(REG_LFO_SHAPE, 32'(SHAPE_TRIANGLE));
    reg_write(REG_RAMP_STEP, 32'd300000);
    sender_quiet = 1;
    feed_random(300);
    drain();

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
